// ===== hw/rtl/swtmr_pkg.sv =====
package swtmr_pkg;

  // Table size and field widths
  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int DELAY_W = 24;
  localparam int TAG_W   = 8;
  localparam int KIND_W  = 2;

  // Input operation, carried on tuser
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Result kind, carried on tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_FIRE   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ADD_RES,
    ST_CHECK,
    ST_SCAN
  } state_t;

  // Free-slot search token, walks from slot 0 upward
  typedef struct packed {
    logic              valid;
    logic              claimed;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic tick;   // decrement pending counts
    logic grant;  // output stage can take a word
  } cell_ctl_t;

  // Fire request from the cell holding the scan token
  typedef struct packed {
    logic              req;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } fire_t;

endpackage

// ===== hw/rtl/software_timer_event_table.sv =====
// Channel | dir | tdata (low bit up)              | tuser       | tlast
// s_*     | in  | delay[23:0], tag[31:24]          | op (0 add)  | -
// m_*     | out | slot[3:0], event_tag[11:4], 0s   | kind[1:0]   | last result of item
//
// An add walks a search token up the slot chain, from slot 0 upward, to its result word.
// A tick decrements all pending slots together as it is taken, then the sequencer checks for due slots.
// If any slot is due, a scan token walks down the chain,
// giving one fire word per due slot, highest slot first.
// Output stalls hold the scan token in the firing cell; a new word is taken
// only when the sequencer is idle. Reset clears all slots.
module software_timer_event_table import swtmr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // delay[23:0], tag[31:24]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // slot[3:0], event_tag[11:4], zero fill
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);

  state_t state, state_next;

  logic               in_acc;
  op_t                op;
  logic               out_free;
  logic               tok_start;
  logic               scan_start;
  logic               res_load;
  logic               fire_load;
  logic               any_due;

  logic [DELAY_W-1:0] hold_delay;
  logic [TAG_W-1:0]   hold_tag;
  logic               claimed_r;
  logic [SLOT_W-1:0]  slot_r;

  tok_t               tok_c [SLOTS+1];
  logic [SLOTS:0]     tok_v;
  logic [SLOTS:0]     scan_c;
  logic [SLOTS:0]     due_c;
  fire_t              fire_c [SLOTS];
  fire_t              fire_any;
  cell_ctl_t          ctl;

  logic [SLOT_W-1:0]  out_slot;
  logic [TAG_W-1:0]   out_tag;

  assign op       = op_t'(s_tuser);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign any_due  = due_c[SLOTS];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (op == OP_ADD) ? ST_ADD : ST_CHECK;
        end
      end
      ST_ADD: begin
        if (tok_c[SLOTS].valid) begin
          state_next = ST_ADD_RES;
        end
      end
      ST_ADD_RES: begin
        if (out_free) begin
          state_next = (claimed_r && any_due) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_next = any_due ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_c[0]) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready   = 1'b0;
    tok_start  = 1'b0;
    scan_start = 1'b0;
    res_load   = 1'b0;
    fire_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        tok_start = s_tvalid && (op == OP_ADD);
      end
      ST_ADD_RES: begin
        res_load   = out_free;
        scan_start = out_free && claimed_r && any_due;
      end
      ST_CHECK: begin
        scan_start = any_due;
      end
      ST_SCAN: begin
        fire_load = fire_any.req && out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Add operands and search outcome
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_delay <= s_tdata[DELAY_W-1:0];
      hold_tag   <= s_tdata[DELAY_W+TAG_W-1:DELAY_W];
    end
    if (tok_c[SLOTS].valid) begin
      claimed_r <= tok_c[SLOTS].claimed;
      slot_r    <= tok_c[SLOTS].slot;
    end
  end

  // Chain ends
  assign tok_c[0]      = '{valid: tok_start, claimed: 1'b0, slot: '0};
  assign scan_c[SLOTS] = scan_start;
  assign due_c[0]      = 1'b0;
  assign ctl           = '{tick: in_acc && (op == OP_TICK), grant: out_free};

  // Slot chain
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    swtmr_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .idx           (SLOT_W'(i)),
      .ctl           (ctl),
      .add_delay     (hold_delay),
      .add_tag       (hold_tag),
      .tok_in        (tok_c[i]),
      .tok_out       (tok_c[i+1]),
      .scan_in       (scan_c[i+1]),
      .scan_out      (scan_c[i]),
      .due_below_in  (due_c[i]),
      .due_below_out (due_c[i+1]),
      .fire          (fire_c[i])
    );
  end

  // Gather the fire word (only the scan holder drives nonzero)
  always_comb begin
    fire_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fire_any.req  = fire_any.req  | fire_c[i].req;
      fire_any.slot = fire_any.slot | fire_c[i].slot;
      fire_any.tag  = fire_any.tag  | fire_c[i].tag;
      fire_any.last = fire_any.last | fire_c[i].last;
    end
    for (int i = 0; i <= SLOTS; i++) begin
      tok_v[i] = tok_c[i].valid;
    end
  end

  // Output register
  assign m_tdata = {4'b0, out_tag, out_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load || fire_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser  <= claimed_r ? KIND_ACCEPT : KIND_FULL;
      out_slot <= claimed_r ? slot_r : '0;
      out_tag  <= hold_tag;
      m_tlast  <= !(claimed_r && any_due);
    end else if (fire_load) begin
      m_tuser  <= KIND_FIRE;
      out_slot <= fire_any.slot;
      out_tag  <= fire_any.tag;
      m_tlast  <= fire_any.last;
    end
  end

  // Checks
  a_scan_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(scan_c))
    else $error("more than one scan token in the slot chain");

  a_tok_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_v))
    else $error("more than one search token in the slot chain");

  a_fire_in_scan: assert property (@(posedge clk) disable iff (rst)
    fire_any.req |-> (state == ST_SCAN))
    else $error("fire request outside a scan");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_tready)
    else $error("new word taken before the previous one finished");

  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (res_load && !claimed_r) |=> (m_tlast && (m_tuser == KIND_FULL)))
    else $error("table-full result not closing its item");

endmodule

// ===== hw/rtl/swtmr_cell.sv =====
module swtmr_cell import swtmr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [SLOT_W-1:0]  idx,
  input  cell_ctl_t          ctl,
  input  logic [DELAY_W-1:0] add_delay,
  input  logic [TAG_W-1:0]   add_tag,
  input  tok_t               tok_in,
  output tok_t               tok_out,
  input  logic               scan_in,
  output logic               scan_out,
  input  logic               due_below_in,
  output logic               due_below_out,
  output fire_t              fire
);

  logic               valid;
  logic [DELAY_W-1:0] remaining;
  logic [TAG_W-1:0]   tag_r;
  tok_t               tok;
  logic               scan;

  logic due;
  logic claim;
  logic hold;
  logic fire_go;

  // Slot state decode
  assign due     = valid && (remaining[DELAY_W-1:1] == '0);
  assign claim   = tok.valid && !tok.claimed && !valid;
  assign hold    = scan && due && !ctl.grant;
  assign fire_go = scan && due && ctl.grant;

  // Token passes on, marked if this slot took the add
  always_comb begin
    tok_out = tok;
    if (claim) begin
      tok_out.claimed = 1'b1;
      tok_out.slot    = idx;
    end
  end

  // Scan token waits here while a due slot cannot be reported
  assign scan_out      = scan && !hold;
  assign due_below_out = due || due_below_in;

  // Fire word for the output stage
  always_comb begin
    fire.req  = scan && due;
    fire.slot = fire.req ? idx : '0;
    fire.tag  = fire.req ? tag_r : '0;
    fire.last = fire.req && !due_below_in;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= '0;
      scan  <= 1'b0;
    end else begin
      tok  <= tok_in;
      scan <= hold ? 1'b1 : scan_in;
      if (claim) begin
        valid <= 1'b1;
      end else if (fire_go) begin
        valid <= 1'b0;
      end
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (claim) begin
      remaining <= add_delay;
      tag_r     <= add_tag;
    end else if (ctl.tick && valid && (remaining != '0)) begin
      remaining <= remaining - DELAY_W'(1);
    end
  end

endmodule
